@@ rtl/core/mpwr_pkg.sv @@
// Shared types and constants for the pixel window render pipeline.
// No dependencies; every module of the block except mpwr_checker imports this package.
package mpwr_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W      = 40;
    localparam int QUO_W      = 8;
    localparam int WID_W      = 31;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STORED_BITS    = 3'd0,
        REG_TOP_BIT        = 3'd1,
        REG_SIGNED_SAMPLES = 3'd2,
        REG_SLOPE          = 3'd3,
        REG_INTERCEPT      = 3'd4,
        REG_WIN_CENTER     = 3'd5,
        REG_WIN_WIDTH      = 3'd6,
        REG_INVERT_OUTPUT  = 3'd7
    } cfg_reg_t;

    // Window region of a pixel
    typedef enum logic [1:0] {
        LVL_LOW  = 2'd0,
        LVL_HIGH = 2'd1,
        LVL_RAMP = 2'd2
    } lvl_t;

    typedef struct packed {
        logic [4:0]         stored_bits;
        logic [3:0]         top_bit;
        logic               signed_samples;
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic signed [31:0] win_center;
        logic [WID_W-1:0]   win_width;
        logic               invert_output;
    } cfg_t;

    typedef struct packed {
        logic               bad;
        logic signed [16:0] sample;
    } align_t;

    typedef struct packed {
        logic               bad;
        logic signed [31:0] mv;
    } modal_t;

    typedef struct packed {
        logic               bad;
        logic signed [31:0] mv;
        lvl_t               lvl;
        logic [ACC_W-1:0]   rem;
        logic [WID_W-1:0]   d;
        logic [QUO_W-1:0]   quo;
    } div_t;

    typedef struct packed {
        logic               bad;
        logic [7:0]         disp;
        logic signed [31:0] mv;
    } result_t;

endpackage

@@ rtl/core/mpwr_align.sv @@
// Bit alignment stage: shift, mask and sign-extend the raw stored word.
// Depends on mpwr_pkg.
module mpwr_align
    import mpwr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [15:0] raw,
    input  cfg_t        cfg,
    output logic        out_valid,
    output align_t      out_data
);

    localparam logic [15:0] SAMPLE_MASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    logic         valid_reg;
    align_t       data_reg;
    align_t       data_next;
    logic [15:0]  raw_m;
    logic [4:0]   top_p1;
    logic         bad;
    logic [3:0]   shift;
    logic [15:0]  shifted;
    logic [16:0]  fmask;
    logic [16:0]  masked;
    logic [4:0]   sidx;
    logic         negv;

    // Decode alignment and extract the stored sample
    always_comb
    begin
        raw_m   = raw & SAMPLE_MASK;
        top_p1  = {1'b0, cfg.top_bit} + 5'd1;
        bad     = (cfg.stored_bits == 5'd0) || (cfg.stored_bits > 5'd16)
                  || (top_p1 < cfg.stored_bits);
        shift   = 4'(top_p1 - cfg.stored_bits);
        shifted = raw_m >> shift;
        fmask   = (17'd1 << cfg.stored_bits) - 17'd1;
        masked  = {1'b0, shifted} & fmask;
        sidx    = 5'(cfg.stored_bits - 5'd1);
        negv    = cfg.signed_samples && masked[sidx];
        data_next.bad    = bad;
        data_next.sample = bad ? 17'sd0
                         : signed'(masked - (negv ? (17'd1 << cfg.stored_bits) : 17'd0));
    end

    // Advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/mpwr_rescale.sv @@
// Modality rescale: multiply by slope, add intercept, round and saturate.
// Two register stages; depends on mpwr_pkg.
module mpwr_rescale
    import mpwr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  align_t in_data,
    input  cfg_t   cfg,
    output logic   out_valid,
    output modal_t out_data
);

    logic               p_valid_reg;
    logic               p_bad_reg;
    logic signed [48:0] prod_reg;
    logic signed [48:0] prod_next;
    logic signed [16:0] sample;
    logic signed [31:0] slope;
    logic signed [31:0] icpt;

    logic               m_valid_reg;
    modal_t             m_reg;
    modal_t             m_next;
    logic signed [49:0] sum;
    logic [10:0]        hi;

    // Multiply the aligned sample by the slope
    always_comb
    begin
        sample    = in_data.sample;
        slope     = cfg.slope;
        prod_next = sample * slope;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= in_valid;
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            p_bad_reg <= in_data.bad;
            m_reg     <= m_next;
        end
    end

    // Add intercept and half, floor to Q24.8, saturate to 32 bits
    always_comb
    begin
        icpt = cfg.intercept;
        sum  = 50'(prod_reg) + (50'(icpt) <<< 8) + 50'sd128;
        hi   = sum[49:39];
        m_next.bad = p_bad_reg;
        if (p_bad_reg)
        begin
            m_next.mv = 32'sd0;
        end
        else if ((hi == 11'h000) || (hi == 11'h7FF))
        begin
            m_next.mv = sum[39:8];
        end
        else if (sum[49])
        begin
            m_next.mv = 32'sh8000_0000;
        end
        else
        begin
            m_next.mv = 32'sh7FFF_FFFF;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_reg;

endmodule

@@ rtl/core/mpwr_window.sv @@
// Linear VOI window: region compare, eight-stage restoring divider, output.
// Depends on mpwr_pkg.
module mpwr_window
    import mpwr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    in_valid,
    input  modal_t  in_data,
    input  cfg_t    cfg,
    output logic    out_valid,
    output result_t out_data
);

    div_t               st_reg   [0:QUO_W];
    logic               vld_reg  [0:QUO_W];
    div_t               st_next;
    logic [WID_W-1:0]   wid;
    logic [WID_W-1:0]   d;
    logic signed [31:0] v;
    logic signed [31:0] c;
    logic signed [33:0] num;
    logic signed [34:0] two_num;
    logic signed [34:0] dd;
    logic signed [41:0] acc;

    logic               r_valid_reg;
    result_t            r_reg;
    result_t            r_next;
    logic [7:0]         lvl_val;

    // Classify against window edges and form the ramp numerator
    always_comb
    begin
        v       = in_data.mv;
        c       = cfg.win_center;
        wid     = (cfg.win_width < 31'd256) ? 31'd256 : cfg.win_width;
        d       = wid - 31'd256;
        num     = 34'(v) - 34'(c) + 34'sd128;
        two_num = {num, 1'b0};
        dd      = signed'({4'b0, d});
        acc     = (42'(num) <<< 8) - 42'(num) + signed'({4'b0, d, 7'b0});
        st_next.bad = in_data.bad;
        st_next.mv  = in_data.mv;
        st_next.rem = acc[ACC_W-1:0];
        st_next.d   = d;
        st_next.quo = '0;
        if (two_num <= -dd)
        begin
            st_next.lvl = LVL_LOW;
        end
        else if (two_num > dd)
        begin
            st_next.lvl = LVL_HIGH;
        end
        else
        begin
            st_next.lvl = LVL_RAMP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= st_next;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int BIT = QUO_W - 1 - k;
        logic [ACC_W-1:0] dsh;
        div_t             div_next;

        always_comb
        begin
            dsh      = 40'(st_reg[k].d) << BIT;
            div_next = st_reg[k];
            if (st_reg[k].rem >= dsh)
            begin
                div_next.rem      = st_reg[k].rem - dsh;
                div_next.quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k+1] <= div_next;
            end
        end
    end

    // Select the grey level, invert, and drop everything on bad alignment
    always_comb
    begin
        case (st_reg[QUO_W].lvl)
            LVL_LOW:  lvl_val = 8'd0;
            LVL_HIGH: lvl_val = 8'd255;
            LVL_RAMP: lvl_val = st_reg[QUO_W].quo;
            default:  lvl_val = 8'd0;
        endcase
        if (cfg.invert_output)
        begin
            lvl_val = 8'd255 - lvl_val;
        end
        r_next.bad  = st_reg[QUO_W].bad;
        r_next.disp = st_reg[QUO_W].bad ? 8'd0 : lvl_val;
        r_next.mv   = st_reg[QUO_W].bad ? 32'sd0 : st_reg[QUO_W].mv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_valid_reg <= vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg <= r_next;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_data  = r_reg;

endmodule

@@ rtl/core/medical_pixel_window_render_unit.sv @@
// Top level of the pixel window renderer: config registers and pipeline.
// Depends on mpwr_pkg, mpwr_align, mpwr_rescale, mpwr_window.
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | tvalid/tready          | tdata[15:0] raw_sample
//  m_axis   | out       | tvalid/tready          | tdata display/modality, tuser bad
//  cfg      | in        | cfg_we (always taken)  | cfg_addr, cfg_wdata
//
// One pixel per clock unless the output stalls; an input transfer passes through
// the align, multiply, sum, window-compare, eight divider and output stages
// to output valid. The whole pipeline moves together: when the output register
// holds an untaken result every stage holds. Reset clears all valid bits and
// loads the configuration defaults.
module medical_pixel_window_render_unit
    import mpwr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] raw_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [7:0] display_value, [39:8] modality_value
    output logic                  m_axis_tuser,   // [0] bad_alignment
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    logic    adv;
    logic    a_valid;
    align_t  a_data;
    logic    m_valid;
    modal_t  m_data;
    result_t r_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stored_bits    <= 5'd16;
            cfg_reg.top_bit        <= 4'd15;
            cfg_reg.signed_samples <= 1'b0;
            cfg_reg.slope          <= 32'sd65536;
            cfg_reg.intercept      <= 32'sd0;
            cfg_reg.win_center     <= 32'sd0;
            cfg_reg.win_width      <= 31'd256;
            cfg_reg.invert_output  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_STORED_BITS:    cfg_reg.stored_bits    <= cfg_wdata[4:0];
                REG_TOP_BIT:        cfg_reg.top_bit        <= cfg_wdata[3:0];
                REG_SIGNED_SAMPLES: cfg_reg.signed_samples <= cfg_wdata[0];
                REG_SLOPE:          cfg_reg.slope          <= cfg_wdata;
                REG_INTERCEPT:      cfg_reg.intercept      <= cfg_wdata;
                REG_WIN_CENTER:     cfg_reg.win_center     <= cfg_wdata;
                REG_WIN_WIDTH:      cfg_reg.win_width      <= cfg_wdata[30:0];
                REG_INVERT_OUTPUT:  cfg_reg.invert_output  <= cfg_wdata[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Advance the pipeline unless a result waits untaken
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    mpwr_align #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .raw       (s_axis_tdata),
        .cfg       (cfg_reg),
        .out_valid (a_valid),
        .out_data  (a_data)
    );

    mpwr_rescale u_rescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (a_valid),
        .in_data   (a_data),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    mpwr_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m_valid),
        .in_data   (m_data),
        .cfg       (cfg_reg),
        .out_valid (m_axis_tvalid),
        .out_data  (r_data)
    );

    assign m_axis_tdata = {r_data.mv, r_data.disp};
    assign m_axis_tuser = r_data.bad;

endmodule

@@ rtl/core/mpwr_checker.sv @@
// Port-level checks of the pixel window renderer, bound to the top level.
// Depends on medical_pixel_window_render_unit.
module mpwr_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [39:0]           m_axis_tdata,
    input logic                  m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // Bad alignment zeroes both result fields
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
        else $error("bad alignment result not zero");

    // Input is taken exactly when the output side can advance
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with pipeline advance");

endmodule

bind medical_pixel_window_render_unit mpwr_checker u_mpwr_checker (.*);

@@ tb/sv/tb_medical_pixel_window_render_unit.sv @@
// Self-checking testbench for the pixel window renderer: drives raw samples
// over the input stream and compares every output transfer with a predictor.
// Depends on mpwr_pkg and medical_pixel_window_render_unit.
module tb_medical_pixel_window_render_unit;
    import mpwr_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int PIPE_LATENCY  = 13;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [7:0]         disp;
        logic signed [31:0] mv;
        logic               bad;
    } pixel_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // [15:0] raw_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;        // [7:0] display_value, [39:8] modality_value
    logic                  m_axis_tuser;        // [0] bad_alignment
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the configuration registers
    logic [4:0]         sh_stored_bits = 5'd16;
    logic [3:0]         sh_top_bit = 4'd15;
    logic               sh_signed = 1'b0;
    logic signed [31:0] sh_slope = 32'sd65536;
    logic signed [31:0] sh_intercept = '0;
    logic signed [31:0] sh_center = '0;
    logic [30:0]        sh_width = 31'd256;
    logic               sh_invert = 1'b0;

    logic [15:0]   pending_samples[$];
    pixel_result_t expected_pixels[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            steady_flow = 1'b0;
    bit            sample_taken = 1'b0;
    int            gap_left = 0;
    int            burst_left = 0;
    logic [7:0]    stall_phase = '0;

    medical_pixel_window_render_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Align, rescale, saturate, window and optionally invert one raw sample
    function automatic pixel_result_t render_pixel(logic [15:0] raw);
        pixel_result_t res;
        int     shift;
        longint smp, acc, mv, c, w, d, num, lvl;
        res   = '0;
        shift = int'(sh_top_bit) + 1 - int'(sh_stored_bits);
        if (sh_stored_bits == 0 || sh_stored_bits > 16 || shift < 0)
        begin
            res.bad = 1'b1;
            return res;
        end
        smp = longint'(raw >> shift) & ((longint'(1) << sh_stored_bits) - 1);
        if (sh_signed && smp[sh_stored_bits - 1])
            smp = smp - (longint'(1) << sh_stored_bits);
        acc = smp * longint'(sh_slope) + longint'(sh_intercept) * 256;
        mv  = (acc + 128) >>> 8;
        if (mv > 64'sd2147483647)
            mv = 64'sd2147483647;
        if (mv < -64'sd2147483648)
            mv = -64'sd2147483648;
        c = longint'(sh_center);
        w = longint'(sh_width);
        if (w < 256)
            w = 256;
        d = w - 256;
        if (d == 0)
            lvl = (mv > c - 128) ? 255 : 0;
        else if (2 * mv <= 2 * c - 256 - d)
            lvl = 0;
        else if (2 * mv > 2 * c - 256 + d)
            lvl = 255;
        else
        begin
            num = mv - c + 128;
            acc = 255 * num + 128 * d;
            if (acc < 0)
                lvl = 0;
            else
            begin
                lvl = acc / d;
                if (lvl > 255)
                    lvl = 255;
            end
        end
        if (sh_invert)
            lvl = 255 - lvl;
        res.disp = lvl[7:0];
        res.mv   = mv[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Sample-side transfer: predict the pixel at the moment it is taken
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_pixels.push_back(render_pixel(pending_samples.pop_front()));
            sample_taken = 1'b1;
        end
    end

    // Sender: bursts of random length with random gaps outside steady flow, hold an untaken sample
    always @(negedge clk)
    begin
        if (s_axis_tvalid && !sample_taken)
        begin
            // keep offering the same sample
        end
        else if (!steady_flow && gap_left > 0)
        begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end
        else if (rst_n && pending_samples.size() > 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_samples[0];
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
        end
        else
            s_axis_tvalid <= 1'b0;
        sample_taken = 1'b0;
    end

    // Receiver: stall in slow windows plus random drops, always ready in steady flow
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 8'd1;
        if (steady_flow)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= (stall_phase[5:4] != 2'b11) && ($urandom_range(0, 3) != 0);
    end

    // Check each result transfer and watch for a stuck pipeline
    always @(posedge clk)
    begin
        pixel_result_t exp_px;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("result with no sample outstanding");
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] !== exp_px.disp)
                    report_mismatch($sformatf("display_value got %0d want %0d",
                                              m_axis_tdata[7:0], exp_px.disp));
                if (m_axis_tdata[39:8] !== exp_px.mv)
                    report_mismatch($sformatf("modality_value got %h want %h",
                                              m_axis_tdata[39:8], exp_px.mv));
                if (m_axis_tuser !== exp_px.bad)
                    report_mismatch($sformatf("bad_alignment got %b want %b",
                                              m_axis_tuser, exp_px.bad));
            end
        end
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_STORED_BITS:    sh_stored_bits = value[4:0];
            REG_TOP_BIT:        sh_top_bit = value[3:0];
            REG_SIGNED_SAMPLES: sh_signed = value[0];
            REG_SLOPE:          sh_slope = value;
            REG_INTERCEPT:      sh_intercept = value;
            REG_WIN_CENTER:     sh_center = value;
            REG_WIN_WIDTH:      sh_width = value[30:0];
            REG_INVERT_OUTPUT:  sh_invert = value[0];
            default:            ;
        endcase
    endtask

    // Load every register, then release the write enable
    task automatic load_setup(logic [4:0] bits, logic [3:0] top, logic sgn,
                              logic [31:0] slope, logic [31:0] icpt,
                              logic [31:0] center, logic [30:0] width, logic inv);
        write_reg(REG_STORED_BITS, {27'd0, bits});
        write_reg(REG_TOP_BIT, {28'd0, top});
        write_reg(REG_SIGNED_SAMPLES, {31'd0, sgn});
        write_reg(REG_SLOPE, slope);
        write_reg(REG_INTERCEPT, icpt);
        write_reg(REG_WIN_CENTER, center);
        write_reg(REG_WIN_WIDTH, {1'b0, width});
        write_reg(REG_INVERT_OUTPUT, {31'd0, inv});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until the pipeline has drained completely
    task automatic drain_pipeline();
        while (pending_samples.size() > 0 || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word(int span);
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return ($urandom_range(0, 1) != 0) ? $urandom_range(0, span)
                                                         : -$urandom_range(0, span);
        endcase
    endfunction

    initial
    begin
        logic [4:0]  bits;
        logic [3:0]  top;
        logic [30:0] width;
        int          w_pick;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: threshold window at zero
        steady_flow = 1'b1;
        pending_samples = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h00FF};
        drain_pipeline();

        // Twelve-bit signed samples in a sixteen-bit word, ramp window
        steady_flow = 1'b0;
        load_setup(5'd12, 4'd11, 1'b1, 32'sd65536, -32'sd262144, 32'sd10240,
                   31'd102400, 1'b0);
        pending_samples = '{16'h0000, 16'h0FFF, 16'h0800, 16'h07FF, 16'hF123};
        drain_pipeline();

        // Bad alignment: top bit too low, zero bits, more than sixteen bits
        load_setup(5'd16, 4'd7, 1'b0, 32'sd65536, 32'sd0, 32'sd0, 31'd256, 1'b1);
        pending_samples = '{16'h1234, 16'hFFFF};
        drain_pipeline();
        load_setup(5'd0, 4'd15, 1'b0, 32'sd65536, 32'sd0, 32'sd0, 31'd256, 1'b0);
        pending_samples = '{16'hABCD};
        drain_pipeline();
        load_setup(5'd20, 4'd15, 1'b1, 32'sd65536, 32'sd0, 32'sd0, 31'd256, 1'b0);
        pending_samples = '{16'h5555};
        drain_pipeline();

        // Modality overflow both ways, widest window, inverted output
        load_setup(5'd16, 4'd15, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   31'h7FFF_FFFF, 1'b1);
        pending_samples = '{16'h7FFF, 16'h8000, 16'h0000};
        drain_pipeline();

        // Zero slope, width below one, one-bit signed sample
        load_setup(5'd1, 4'd0, 1'b1, 32'sd0, 32'h8000_0000, 32'h7FFF_FFFF,
                   31'd0, 1'b1);
        pending_samples = '{16'h0000, 16'h0001, 16'hFFFE};
        drain_pipeline();

        // Random setups, each with a burst of random samples
        for (int ph = 0; ph < 12; ph++)
        begin
            steady_flow = (ph % 4 == 3);
            if ($urandom_range(0, 9) == 0)
            begin
                bits = $urandom_range(0, 31);
                top  = $urandom_range(0, 15);
            end
            else
            begin
                bits = $urandom_range(1, 16);
                top  = $urandom_range(bits - 1, 15);
            end
            w_pick = $urandom_range(0, 3);
            width  = (w_pick == 0) ? 31'($urandom) :
                     (w_pick == 1) ? 31'($urandom_range(0, 300)) :
                                     31'($urandom_range(256, 32'h0100_0000));
            load_setup(bits, top, $urandom_range(0, 1), pick_word(262144),
                       pick_word(32'h0080_0000), pick_word(32'h0100_0000), width,
                       $urandom_range(0, 1));
            repeat (56) pending_samples.push_back($urandom_range(0, 16'hFFFF));
            drain_pipeline();
        end

        if (error_count == 0 && expected_pixels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mpwr_pkg.sv
rtl/core/mpwr_align.sv
rtl/core/mpwr_rescale.sv
rtl/core/mpwr_window.sv
rtl/core/medical_pixel_window_render_unit.sv
rtl/core/mpwr_checker.sv
tb/sv/tb_medical_pixel_window_render_unit.sv
